// ===== hdl/vdq_pkg.sv =====
// ----------------------------------------------------------------------------
// vdq_pkg
// Types, constants and elaboration-time sin/cos tables for the vector
// direction quantizer.
// ----------------------------------------------------------------------------
package vdq_pkg;

   typedef logic [5:0]  cnt_type;
   typedef logic [8:0]  deg_type;
   typedef logic [63:0] tab_type [0:63];
   typedef logic [63:0] div_type [0:39];

   typedef struct packed {
      cnt_type cnt;
      logic    ge;
      logic    dx_neg;
      logic    dy_zero;
      logic    dy_neg;
   } srch_type;

   localparam int      SRCH_STEPS = 6;
   localparam int      ANG_LAST   = 44;
   localparam int      SER_TERMS  = 40;

   localparam deg_type DEG_45  = 9'd45;
   localparam deg_type DEG_90  = 9'd90;
   localparam deg_type DEG_180 = 9'd180;
   localparam deg_type DEG_270 = 9'd270;
   localparam deg_type DEG_360 = 9'd360;

   // sector = (256*deg + 179) / 360, via reciprocal ceil(2^32/360)
   localparam logic [16:0] SECT_ROUND = 17'd179;
   localparam logic [23:0] SECT_RECIP = 24'd11930465;
   localparam int          SECT_SHIFT = 32;

   localparam logic [63:0] LOW32    = 64'h0000_0000_FFFF_FFFF;
   localparam logic [63:0] PI_INT   = 64'd3;
   localparam logic [63:0] PI_FRAC  = 64'h243F_6A88_85A3_08D3;
   localparam logic [63:0] DEG_DIV  = 64'd180;

   function automatic div_type mk_div(input logic cos_form);
      div_type d;
      d[0] = 64'd1;
      for (int i = 1; i < SER_TERMS; i++) begin
         if (cos_form) d[i] = 64'((2 * i - 1) * (2 * i));
         else          d[i] = 64'((2 * i) * (2 * i + 1));
      end
      return d;
   endfunction

   localparam div_type SIN_DIV = mk_div(1'b0);
   localparam div_type COS_DIV = mk_div(1'b1);

   function automatic logic [63:0] fix_mul(input logic [63:0] x, input logic [63:0] y);
      logic [127:0] p;
      p = {64'd0, x} * {64'd0, y};
      return p[127:64];
   endfunction

   function automatic logic [63:0] one_deg();
      logic [63:0] num, q1, r1, q0;
      num = (PI_INT << 32) + (PI_FRAC >> 32);
      q1  = num / DEG_DIV;
      r1  = num % DEG_DIV;
      q0  = ((r1 << 32) + (PI_FRAC & LOW32)) / DEG_DIV;
      return (q1 << 32) | q0;
   endfunction

   // 0.64 fixed-point sin (or 1 - cos, negated) of 1..44 degrees
   function automatic tab_type build_tab(input logic want_cos);
      tab_type     tab;
      logic [63:0] od, th, sq, term, s, v, t2;
      od = one_deg();
      for (int k = 0; k < 64; k++) tab[k] = 64'd0;
      for (int k = 1; k <= ANG_LAST; k++) begin
         th   = od * 64'(k);
         sq   = fix_mul(th, th);
         term = th;
         s    = th;
         for (int i = 1; i < SER_TERMS; i++) begin
            if (term != 64'd0) begin
               term = fix_mul(term, sq) / SIN_DIV[i];
               if ((i & 1) != 0) s = s - term;
               else              s = s + term;
            end
         end
         v  = sq >> 1;
         t2 = v;
         for (int i = 2; i < SER_TERMS; i++) begin
            if (t2 != 64'd0) begin
               t2 = fix_mul(t2, sq) / COS_DIV[i];
               if ((i & 1) != 0) v = v + t2;
               else              v = v - t2;
            end
         end
         tab[k] = want_cos ? (64'd0 - v) : s;
      end
      return tab;
   endfunction

   function automatic tab_type mirror_tab(input tab_type t);
      tab_type m;
      for (int j = 0; j < 64; j++) m[j] = 64'd0;
      for (int j = 1; j <= ANG_LAST; j++) m[j] = t[ANG_LAST + 1 - j];
      return m;
   endfunction

   localparam tab_type SIN_TAB = build_tab(1'b0);
   localparam tab_type COS_TAB = build_tab(1'b1);

   // test a*T1[j] >= b*T2[j]; true for j = 1..count in both halves
   localparam tab_type LT_T1 = COS_TAB;
   localparam tab_type LT_T2 = SIN_TAB;
   localparam tab_type GE_T1 = mirror_tab(SIN_TAB);
   localparam tab_type GE_T2 = mirror_tab(COS_TAB);

endpackage

// ===== hdl/vector_direction_quantizer.sv =====
// ----------------------------------------------------------------------------
// vector_direction_quantizer
// Pipelined compass bearing (0 up, clockwise) between two screen points, in
// whole degrees and in 256 sectors.
// ----------------------------------------------------------------------------
//  channel   ports                                      transfer
//  --------  -----------------------------------------  ----------------------
//  request   start, busy, req_from_x/y, req_to_x/y      start && !busy
//  response  rsp_valid, rsp_bearing_degrees,            rsp_valid, one cycle
//            rsp_direction_sector
//
//  One request per cycle; busy stays low.
//  The quadrant angle is found by a 6-step binary search over the 44 degree
//  thresholds, two stages per step (partial products, then wide compare).
//  Synchronous reset clears the valid chain only; data registers are free.
//  No stall path: every stage advances each cycle.
// ----------------------------------------------------------------------------
module vector_direction_quantizer #(
   parameter int COORD_WIDTH = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic signed [COORD_WIDTH-1:0] req_from_x,
   input  logic signed [COORD_WIDTH-1:0] req_from_y,
   input  logic signed [COORD_WIDTH-1:0] req_to_x,
   input  logic signed [COORD_WIDTH-1:0] req_to_y,
   output logic                          rsp_valid,
   output logic [8:0]                    rsp_bearing_degrees,
   output logic [7:0]                    rsp_direction_sector
);

   localparam int DW    = COORD_WIDTH + 1;
   localparam int PW    = COORD_WIDTH + 32;
   localparam int SW    = COORD_WIDTH + 64;
   localparam int STEPS = vdq_pkg::SRCH_STEPS;
   localparam int LAT   = 4 + 2 * STEPS;

   logic accept;
   logic [LAT-1:0] vld_ff;

   // difference stage
   logic [DW-1:0] dx_in, dy_in, dx_ff, dy_ff;

   // prep stage
   logic [COORD_WIDTH-1:0] ax_in, ay_in;
   logic [DW-1:0]          nx_in, ny_in;
   vdq_pkg::srch_type      ctl0_in;

   // search pipeline
   logic [COORD_WIDTH-1:0] sa_ff   [0:STEPS];
   logic [COORD_WIDTH-1:0] sb_ff   [0:STEPS];
   vdq_pkg::srch_type      sctl_ff [0:STEPS];
   logic [COORD_WIDTH-1:0] ma_ff   [0:STEPS-1];
   logic [COORD_WIDTH-1:0] mb_ff   [0:STEPS-1];
   vdq_pkg::srch_type      mctl_ff [0:STEPS-1];
   vdq_pkg::cnt_type       mj_ff   [0:STEPS-1];
   logic                   mok_ff  [0:STEPS-1];
   logic [PW-1:0]          m1h_ff  [0:STEPS-1];
   logic [PW-1:0]          m1l_ff  [0:STEPS-1];
   logic [PW-1:0]          m2h_ff  [0:STEPS-1];
   logic [PW-1:0]          m2l_ff  [0:STEPS-1];

   // bearing and sector stages
   vdq_pkg::deg_type n_in, deg_in, deg_ff;
   logic [16:0]      sx_in;
   logic [40:0]      sprod_in;
   vdq_pkg::deg_type rsp_bearing_degrees_ff;
   logic [7:0]       rsp_direction_sector_ff;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[LAT-2:0], accept};
      end
   end

   always_comb begin
      dx_in = {req_to_x[COORD_WIDTH-1], req_to_x} - {req_from_x[COORD_WIDTH-1], req_from_x};
      dy_in = {req_to_y[COORD_WIDTH-1], req_to_y} - {req_from_y[COORD_WIDTH-1], req_from_y};
   end

   always_ff @(posedge clock) begin
      dx_ff <= dx_in;
      dy_ff <= dy_in;
   end

   always_comb begin
      nx_in           = DW'(0) - dx_ff;
      ny_in           = DW'(0) - dy_ff;
      ax_in           = dx_ff[DW-1] ? nx_in[COORD_WIDTH-1:0] : dx_ff[COORD_WIDTH-1:0];
      ay_in           = dy_ff[DW-1] ? ny_in[COORD_WIDTH-1:0] : dy_ff[COORD_WIDTH-1:0];
      ctl0_in.cnt     = '0;
      ctl0_in.ge      = ax_in >= ay_in;
      ctl0_in.dx_neg  = dx_ff[DW-1];
      ctl0_in.dy_zero = dy_ff == '0;
      ctl0_in.dy_neg  = dy_ff[DW-1];
   end

   always_ff @(posedge clock) begin
      sa_ff[0]   <= ax_in;
      sb_ff[0]   <= ay_in;
      sctl_ff[0] <= ctl0_in;
   end

   for (genvar s = 0; s < STEPS; s++) begin : g_step
      localparam int BIT = STEPS - 1 - s;

      vdq_pkg::cnt_type  j_in;
      logic              jok_in;
      logic [63:0]       t1_in, t2_in;
      logic [SW-1:0]     p1_in, p2_in;
      vdq_pkg::srch_type ctl_in;

      always_comb begin
         j_in   = sctl_ff[s].cnt | vdq_pkg::cnt_type'(1 << BIT);
         jok_in = 32'(j_in) <= vdq_pkg::ANG_LAST;
         t1_in  = sctl_ff[s].ge ? vdq_pkg::GE_T1[j_in] : vdq_pkg::LT_T1[j_in];
         t2_in  = sctl_ff[s].ge ? vdq_pkg::GE_T2[j_in] : vdq_pkg::LT_T2[j_in];
      end

      always_ff @(posedge clock) begin
         ma_ff[s]   <= sa_ff[s];
         mb_ff[s]   <= sb_ff[s];
         mctl_ff[s] <= sctl_ff[s];
         mj_ff[s]   <= j_in;
         mok_ff[s]  <= jok_in;
         m1h_ff[s]  <= PW'(sa_ff[s]) * PW'(t1_in[63:32]);
         m1l_ff[s]  <= PW'(sa_ff[s]) * PW'(t1_in[31:0]);
         m2h_ff[s]  <= PW'(sb_ff[s]) * PW'(t2_in[63:32]);
         m2l_ff[s]  <= PW'(sb_ff[s]) * PW'(t2_in[31:0]);
      end

      always_comb begin
         p1_in  = {m1h_ff[s], 32'd0} + SW'(m1l_ff[s]);
         p2_in  = {m2h_ff[s], 32'd0} + SW'(m2l_ff[s]);
         ctl_in = mctl_ff[s];
         if (mok_ff[s] && (p1_in >= p2_in)) begin
            ctl_in.cnt = mj_ff[s];
         end
      end

      always_ff @(posedge clock) begin
         sa_ff[s+1]   <= ma_ff[s];
         sb_ff[s+1]   <= mb_ff[s];
         sctl_ff[s+1] <= ctl_in;
      end
   end

   always_comb begin
      n_in = sctl_ff[STEPS].ge ? vdq_pkg::DEG_45 + vdq_pkg::deg_type'(sctl_ff[STEPS].cnt)
                               : vdq_pkg::deg_type'(sctl_ff[STEPS].cnt);
      if (sctl_ff[STEPS].dy_zero) begin
         deg_in = sctl_ff[STEPS].dx_neg ? vdq_pkg::DEG_270 : vdq_pkg::DEG_90;
      end else begin
         case ({sctl_ff[STEPS].dx_neg, sctl_ff[STEPS].dy_neg})
            2'b01:   deg_in = n_in;
            2'b00:   deg_in = vdq_pkg::DEG_180 - n_in;
            2'b11:   deg_in = vdq_pkg::DEG_360 - n_in;
            default: deg_in = vdq_pkg::DEG_180 + n_in;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      deg_ff <= deg_in;
   end

   always_comb begin
      sx_in    = {deg_ff, 8'd0} + vdq_pkg::SECT_ROUND;
      sprod_in = {24'd0, sx_in} * {17'd0, vdq_pkg::SECT_RECIP};
   end

   always_ff @(posedge clock) begin
      rsp_bearing_degrees_ff  <= deg_ff;
      rsp_direction_sector_ff <= sprod_in[vdq_pkg::SECT_SHIFT+7:vdq_pkg::SECT_SHIFT];
   end

   assign rsp_valid            = vld_ff[LAT-1];
   assign rsp_bearing_degrees  = rsp_bearing_degrees_ff;
   assign rsp_direction_sector = rsp_direction_sector_ff;

   a_lat_fwd: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##LAT rsp_valid)
      else $error("transfer did not produce a response after pipeline latency");

   a_lat_back: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, LAT))
      else $error("response without a matching request transfer");

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      vld_ff[2*STEPS+1] |-> (32'(sctl_ff[STEPS].cnt) <= vdq_pkg::ANG_LAST))
      else $error("search count beyond last threshold");

   a_deg_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_bearing_degrees <= vdq_pkg::DEG_360))
      else $error("bearing out of range");

endmodule
